// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_BLOCKS = 1024;
   localparam int DEF_WORD_BITS  = 32;

   // Fixed field widths
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int STATUS_W = 2;

   // Count register reset value
   localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

   // Fixed-point shift for the reciprocal that splits an index into word and bit
   localparam int DIV_SHIFT = IDX_W + 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE       = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVQ,
      ST_DIVR,
      ST_MODIFY,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Flags returned by the word scanner
   typedef struct packed {
      logic found;   // a free block lies in this word below the count
      logic last;    // this word reaches the block count
   } scan_flags_type;

endpackage

`default_nettype wire

// ===== rtl/bba_bitmap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_bitmap_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW    = 5
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bba_word_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_word_scan #(
   parameter int WORD_BITS = 32,
   parameter int PW        = 5,
   parameter int CW        = 11
) (
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic [CW-1:0]        base,
   input  wire logic [CW-1:0]        limit,
   output bba_pkg::scan_flags_type   flags,
   output logic      [PW-1:0]        pos
);

   logic [CW-1:0] span;

   // Bits of this word that lie below the block count
   always_comb begin
      span = (limit > base) ? (limit - base) : '0;
   end

   // Lowest clear bit within the span
   always_comb begin
      flags.found = 1'b0;
      pos         = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!word[b] && (CW'(b) < span)) begin
            flags.found = 1'b1;
            pos         = PW'(b);
         end
      end
      flags.last = (CW'(base + CW'(WORD_BITS)) >= limit);
   end

endmodule

`default_nettype wire

// ===== rtl/block_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-fit block allocator over a bitmap of used blocks held in one synchronous
// RAM of ceil(MAX_BLOCKS / WORD_BITS) words, one bit per block, 1 meaning used.
// One request is handled at a time. Allocate scans the bitmap one RAM word per
// cycle from word 0 and sets the lowest clear bit below the live block count,
// reading between 1 and ceil(MAX_BLOCKS / WORD_BITS) words (32 at the defaults)
// through the single RAM read port. Free, set, clear and query split the index
// into word and bit in the DIVQ and DIVR states, read the word and, for free,
// set and clear, write it back; an index out of range goes from DIVQ straight
// to its range result. The result sits in an output register, so a new request
// is taken while the previous result still waits for its transfer. After reset
// a clearing pass writes every RAM word, one a cycle, marking blocks 0 and 1
// used; no request is taken meanwhile, while block count writes are taken at
// any time. The live count is min(block_count, MAX_BLOCKS).

module block_bitmap_allocator_unit #(
   parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [bba_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [bba_pkg::IDX_W-1:0]     req_block_index,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [bba_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [bba_pkg::IDX_W-1:0]     rsp_result_index,
   output logic                               rsp_bit_value,
   // block count register
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bba_pkg::CNT_W-1:0]     csr_block_count
);

   localparam int IDX_W     = bba_pkg::IDX_W;
   localparam int CNT_W     = bba_pkg::CNT_W;
   localparam int CMD_W     = bba_pkg::CMD_W;
   localparam int STATUS_W  = bba_pkg::STATUS_W;
   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW        = $clog2(WORD_BITS);
   localparam int CW_RAW    = $clog2(MAP_WORDS * WORD_BITS + 2 * WORD_BITS + 1);
   localparam int CW        = (CW_RAW > CNT_W) ? CW_RAW : CNT_W;
   localparam int RECIP     = (2 ** bba_pkg::DIV_SHIFT) / WORD_BITS;
   localparam int RW        = $clog2(RECIP + 1);
   localparam int PRW       = IDX_W + RW;

   localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [WORD_BITS-1:0] ONE_BIT   = WORD_BITS'(1);
   localparam logic [WORD_BITS-1:0] INIT_WORD = WORD_BITS'(3);

   // control
   bba_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    quo_ff, quo_in;
   logic [AW-1:0]       word_ff, word_in;
   logic [PW-1:0]       bit_ff, bit_in;
   logic [AW-1:0]       scan_w_ff, scan_w_in;
   logic [CW-1:0]       base_ff, base_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_index_ff, res_index_in;
   logic                res_bit_ff, res_bit_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                rsp_bit_ff, rsp_bit_in;

   // RAM port
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // datapath helpers
   logic [CW-1:0]        live_count;
   logic                 in_range;
   logic [PRW-1:0]       quo_prod;
   logic [IDX_W-1:0]     quo_est;
   logic [IDX_W:0]       rem_raw;
   logic                 rem_fix;
   logic [IDX_W-1:0]     quo_fix;
   logic [PW-1:0]        rem_bit;
   logic [WORD_BITS-1:0] bit_mask;
   logic                 cur_bit;
   logic                 rsp_free;
   logic                 accept;

   bba_pkg::scan_flags_type scan_flags;
   logic [PW-1:0]           scan_pos;
   logic [CW-1:0]           alloc_index;

   bba_bitmap_ram #(
      .DEPTH (MAP_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bba_word_scan #(
      .WORD_BITS (WORD_BITS),
      .PW        (PW),
      .CW        (CW)
   ) u_scan (
      .word  (ram_rd_data),
      .base  (base_ff),
      .limit (live_count),
      .flags (scan_flags),
      .pos   (scan_pos)
   );

   // Shared arithmetic
   always_comb begin
      live_count = (CW'(count_ff) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_ff);
      in_range   = CW'(idx_ff) < live_count;

      // word = index / WORD_BITS by reciprocal; the estimate is low by at most one
      quo_prod = PRW'(idx_ff) * PRW'(RECIP);
      quo_est  = IDX_W'(quo_prod >> bba_pkg::DIV_SHIFT);
      rem_raw  = {1'b0, idx_ff} - (IDX_W + 1)'(quo_ff * WORD_BITS);
      rem_fix  = rem_raw >= (IDX_W + 1)'(WORD_BITS);
      quo_fix  = quo_ff + IDX_W'(rem_fix);
      rem_bit  = rem_fix ? PW'(rem_raw - (IDX_W + 1)'(WORD_BITS)) : PW'(rem_raw);

      bit_mask    = ONE_BIT << bit_ff;
      cur_bit     = ram_rd_data[bit_ff];
      alloc_index = base_ff + CW'(scan_pos);

      rsp_free = !rsp_valid_ff || rsp_ready;
      accept   = req_valid && req_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_WORD) state_in = bba_pkg::ST_IDLE;
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == bba_pkg::CMD_ALLOC) ? bba_pkg::ST_SCAN
                                                          : bba_pkg::ST_DIVQ;
            end
         end
         bba_pkg::ST_DIVQ: begin
            state_in = in_range ? bba_pkg::ST_DIVR : bba_pkg::ST_DONE;
         end
         bba_pkg::ST_DIVR: begin
            state_in = bba_pkg::ST_MODIFY;
         end
         bba_pkg::ST_MODIFY: begin
            state_in = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_SCAN: begin
            if (scan_flags.found || scan_flags.last) state_in = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_DONE: begin
            if (rsp_free) state_in = bba_pkg::ST_IDLE;
         end
         default: state_in = bba_pkg::ST_IDLE;
      endcase
   end

   // Handshake and RAM controls
   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = word_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = '0;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            // sweep the map: word 0 carries the two reserved blocks
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = (clr_ff == '0) ? INIT_WORD : '0;
         end
         bba_pkg::ST_IDLE: begin
            // word 0 is fetched at the transfer, ready for a scan
            req_ready   = 1'b1;
            ram_rd_addr = '0;
         end
         bba_pkg::ST_DIVQ: begin
            ram_rd_addr = '0;
         end
         bba_pkg::ST_DIVR: begin
            ram_rd_addr = AW'(quo_fix);
         end
         bba_pkg::ST_MODIFY: begin
            ram_wr_addr = word_ff;
            ram_rd_addr = word_ff;
            case (cmd_ff)
               bba_pkg::CMD_FREE: begin
                  ram_wr_en   = cur_bit;
                  ram_wr_data = ram_rd_data & ~bit_mask;
               end
               bba_pkg::CMD_SET: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data | bit_mask;
               end
               bba_pkg::CMD_CLEAR: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data & ~bit_mask;
               end
               default: begin
                  ram_wr_en = 1'b0;
               end
            endcase
         end
         bba_pkg::ST_SCAN: begin
            // fetch one word ahead; claim the free bit when found
            ram_rd_addr = (scan_w_ff == LAST_WORD) ? scan_w_ff : scan_w_ff + AW'(1);
            ram_wr_en   = scan_flags.found;
            ram_wr_addr = scan_w_ff;
            ram_wr_data = ram_rd_data | (ONE_BIT << scan_pos);
         end
         bba_pkg::ST_DONE: begin
            ram_rd_addr = '0;
         end
         default: begin
            ram_rd_addr = '0;
         end
      endcase
   end

   // Register next values
   always_comb begin
      clr_in        = clr_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      quo_in        = quo_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      scan_w_in     = scan_w_ff;
      base_in       = base_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_bit_in    = res_bit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_bit_in    = rsp_bit_ff;

      if (csr_valid) count_in = csr_block_count;

      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               idx_in    = req_block_index;
               scan_w_in = '0;
               base_in   = '0;
            end
         end
         bba_pkg::ST_DIVQ: begin
            quo_in        = quo_est;
            res_status_in = bba_pkg::STATUS_RANGE;
            res_index_in  = idx_ff;
            res_bit_in    = 1'b0;
         end
         bba_pkg::ST_DIVR: begin
            word_in = AW'(quo_fix);
            bit_in  = rem_bit;
         end
         bba_pkg::ST_MODIFY: begin
            res_index_in = idx_ff;
            case (cmd_ff)
               bba_pkg::CMD_FREE: begin
                  res_status_in = cur_bit ? bba_pkg::STATUS_OK : bba_pkg::STATUS_DOUBLE_FREE;
                  res_bit_in    = 1'b0;
               end
               bba_pkg::CMD_SET: begin
                  res_status_in = bba_pkg::STATUS_OK;
                  res_bit_in    = 1'b1;
               end
               bba_pkg::CMD_CLEAR: begin
                  res_status_in = bba_pkg::STATUS_OK;
                  res_bit_in    = 1'b0;
               end
               default: begin
                  // query, and the unused codes that behave as query
                  res_status_in = bba_pkg::STATUS_OK;
                  res_bit_in    = cur_bit;
               end
            endcase
         end
         bba_pkg::ST_SCAN: begin
            if (scan_flags.found) begin
               res_status_in = bba_pkg::STATUS_OK;
               res_index_in  = IDX_W'(alloc_index);
               res_bit_in    = 1'b1;
            end else if (scan_flags.last) begin
               res_status_in = bba_pkg::STATUS_FULL;
               res_index_in  = '0;
               res_bit_in    = 1'b0;
            end else begin
               scan_w_in = scan_w_ff + AW'(1);
               base_in   = base_ff + CW'(WORD_BITS);
            end
         end
         bba_pkg::ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_bit_in    = res_bit_ff;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= bba_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      quo_ff        <= quo_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      scan_w_ff     <= scan_w_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_bit_ff    <= res_bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_bit_ff    <= rsp_bit_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_bit_value    = rsp_bit_ff;

endmodule

`default_nettype wire

// ===== bench/block_bitmap_allocator_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the first-fit block allocator. Requests go in on the
// req_ channel, results come back on the rsp_ channel and the block count goes
// in through the csr_ port. A behavioural copy of the bitmap predicts every
// result at the moment its request transfer happens. A checker compares each
// result transfer, field by field, with the oldest prediction.
module block_bitmap_allocator_unit_test;

   localparam int CMD_W         = bba_pkg::CMD_W;
   localparam int IDX_W         = bba_pkg::IDX_W;
   localparam int CNT_W         = bba_pkg::CNT_W;
   localparam int STATUS_W      = bba_pkg::STATUS_W;
   localparam int MAP_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS;
   localparam int IDLE_PERCENT  = 12;
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int STALL_LIMIT   = 2000;   // cycles without any transfer
   localparam int SETTLE_CYCLES = 40;     // worst allocate scan plus margin

   // Command codes the block does not define; it treats them as a query
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    result_index;
      logic                bit_value;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [IDX_W-1:0]    req_block_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic                rsp_bit_value;
   logic                csr_valid;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_block_count;

   // Predicted state of the block
   logic [MAP_BLOCKS-1:0] block_used;
   logic [CNT_W-1:0]      count_setting;

   outcome_type pending_outcomes[$];
   int          mismatch_count;
   int          stalled_cycles;
   bit          idle_enable;
   int          hold_requests;
   int          hold_served;

   block_bitmap_allocator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_bit_value    (rsp_bit_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_block_count  (csr_block_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Allocator prediction
   // ------------------------------------------------------------------

   // Counts above the map size act as the map size
   function automatic int live_blocks();
      return (count_setting > MAP_BLOCKS) ? MAP_BLOCKS : int'(count_setting);
   endfunction

   // Apply one request to the predicted bitmap and return its result
   function automatic outcome_type allocator_outcome(logic [CMD_W-1:0] cmd,
                                                     logic [IDX_W-1:0] idx);
      outcome_type o;
      int          n;
      bit          found;
      n              = live_blocks();
      found          = 1'b0;
      o.status       = bba_pkg::STATUS_OK;
      o.result_index = idx;
      o.bit_value    = 1'b0;
      if (cmd == bba_pkg::CMD_ALLOC) begin
         // first fit: lowest clear bit below the live count
         o.status       = bba_pkg::STATUS_FULL;
         o.result_index = '0;
         for (int i = 0; i < n && !found; i++) begin
            if (!block_used[i]) begin
               block_used[i]  = 1'b1;
               found          = 1'b1;
               o.status       = bba_pkg::STATUS_OK;
               o.result_index = IDX_W'(i);
               o.bit_value    = 1'b1;
            end
         end
      end else if (int'(idx) >= n) begin
         o.status = bba_pkg::STATUS_RANGE;
      end else begin
         case (cmd)
            bba_pkg::CMD_FREE: begin
               if (!block_used[idx])
                  o.status = bba_pkg::STATUS_DOUBLE_FREE;
               else
                  block_used[idx] = 1'b0;
            end
            bba_pkg::CMD_SET: begin
               block_used[idx] = 1'b1;
               o.bit_value     = 1'b1;
            end
            bba_pkg::CMD_CLEAR: begin
               block_used[idx] = 1'b0;
            end
            default: begin
               // query, and the spare codes behave the same way
               o.bit_value = block_used[idx];
            end
         endcase
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one request; predict its result on the transfer. Valid stays high
   // after the transfer until the next falling edge decides what comes next.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
      @(negedge clock);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_block_index <= idx;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(allocator_outcome(cmd, idx));
   endtask

   // Drop valid once the last request of a stretch has gone
   task automatic end_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Hold the sender until every predicted result has been checked
   task automatic wait_drained();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Write the block count; only ever called with no request outstanding
   task automatic write_block_count(logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_block_count <= value;
      do @(posedge clock); while (!csr_ready);
      count_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Weighted command choice; alloc_weight is a percentage
   function automatic logic [CMD_W-1:0] pick_cmd(int alloc_weight);
      int r;
      r = $urandom_range(0, 99);
      if (r < alloc_weight)
         return bba_pkg::CMD_ALLOC;
      r = $urandom_range(0, 99);
      if (r < 40) return bba_pkg::CMD_FREE;
      if (r < 58) return bba_pkg::CMD_SET;
      if (r < 76) return bba_pkg::CMD_CLEAR;
      if (r < 92) return bba_pkg::CMD_QUERY;
      return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
   endfunction

   // Mostly in range, so the bitmap really changes; the rest anywhere
   function automatic logic [IDX_W-1:0] pick_index();
      int n;
      n = live_blocks();
      if (n > 0 && $urandom_range(0, 99) < 90)
         return IDX_W'($urandom_range(0, n - 1));
      return IDX_W'($urandom);
   endfunction

   task automatic run_random_phase(logic [CNT_W-1:0] count, int items, int alloc_weight);
      wait_drained();
      write_block_count(count);
      for (int i = 0; i < items; i++)
         send_request(pick_cmd(alloc_weight), pick_index());
      end_requests();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset bitmap, every command and the spare codes at the full count
   task automatic test_basic_commands();
      write_block_count(bba_pkg::COUNT_RESET);
      send_request(bba_pkg::CMD_ALLOC, '1);        // blocks 0 and 1 used: grants 2
      send_request(bba_pkg::CMD_ALLOC, '0);        // grants 3
      send_request(bba_pkg::CMD_QUERY, 10'd0);
      send_request(bba_pkg::CMD_QUERY, 10'd1);
      send_request(bba_pkg::CMD_QUERY, '1);
      send_request(bba_pkg::CMD_FREE, 10'd3);
      send_request(bba_pkg::CMD_FREE, 10'd3);      // double free
      send_request(bba_pkg::CMD_SET, '1);
      send_request(bba_pkg::CMD_QUERY, '1);
      send_request(bba_pkg::CMD_CLEAR, '1);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_request(CMD_W'(c), 10'd2);
      send_request(bba_pkg::CMD_FREE, 10'd0);
      end_requests();
   endtask

   // Count extremes: oversized, zero, one and two blocks
   task automatic test_count_extremes();
      wait_drained();
      write_block_count('1);              // acts as the map size
      send_request(bba_pkg::CMD_QUERY, '1);
      end_requests();
      wait_drained();
      write_block_count('0);              // nothing reachable
      send_request(bba_pkg::CMD_ALLOC, 10'd0);
      send_request(bba_pkg::CMD_QUERY, 10'd0);
      send_request(bba_pkg::CMD_SET, 10'd0);
      end_requests();
      wait_drained();
      write_block_count(11'd1);
      send_request(bba_pkg::CMD_ALLOC, 10'd0);     // block 0 was freed: grants 0
      send_request(bba_pkg::CMD_ALLOC, 10'd0);     // now full
      end_requests();
      wait_drained();
      write_block_count(11'd2);
      send_request(bba_pkg::CMD_FREE, 10'd1);
      send_request(bba_pkg::CMD_ALLOC, 10'd0);
      send_request(bba_pkg::CMD_SET, 10'd2);       // just past the count
      send_request(bba_pkg::CMD_FREE, '1);
      end_requests();
   endtask

   // Random traffic over several counts; small counts fill up and run dry
   task automatic test_random_traffic();
      run_random_phase(bba_pkg::COUNT_RESET, 60, 40);
      run_random_phase(11'd40, 80, 55);
      run_random_phase(11'd8, 60, 50);
      run_random_phase('1, 50, 35);
      run_random_phase(11'd33, 60, 45);
      run_random_phase(11'($urandom_range(2, MAP_BLOCKS)), 60, 30);
   endtask

   // Back-to-back traffic against a long receiver hold-off, a pause, then more
   task automatic test_backpressure();
      wait_drained();
      write_block_count(11'd64);
      idle_enable = 1'b0;
      hold_requests++;
      for (int i = 0; i < 40; i++)
         send_request(pick_cmd(50), pick_index());
      end_requests();
      wait_drained();
      for (int i = 0; i < 20; i++)
         send_request(pick_cmd(50), pick_index());
      end_requests();
      idle_enable = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = '0;
      req_block_index = '0;
      csr_valid       = 1'b0;
      csr_block_count = '0;
      idle_enable     = 1'b1;
      hold_requests   = 0;
      block_used      = '0;
      block_used[1:0] = 2'b11;
      count_setting   = bba_pkg::COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_count_extremes();
      test_random_traffic();
      test_backpressure();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random idling, or a long hold-off when one is requested
   initial begin
      rsp_ready   = 1'b0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= !(idle_enable && $urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Checker: every result transfer against the oldest prediction
   initial mismatch_count = 0;
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result with no request outstanding: status %0d index %0d bit %0d",
                     $time, rsp_status, rsp_result_index, rsp_bit_value);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_result_index !== want.result_index) begin
               $display("%0t: result_index expected %0d, actual %0d",
                        $time, want.result_index, rsp_result_index);
               mismatch_count++;
            end
            if (rsp_bit_value !== want.bit_value) begin
               $display("%0t: bit_value expected %0d, actual %0d",
                        $time, want.bit_value, rsp_bit_value);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer of any kind happens for too long
   initial stalled_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_bitmap_ram.sv
rtl/bba_word_scan.sv
rtl/block_bitmap_allocator_unit.sv
bench/block_bitmap_allocator_unit_test.sv
